### rtl/sdsr_pkg.sv
// Shared types and constants for the data stack with dup, swap and rot.
package sdsr_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int OFF_W    = 6;
    localparam int STATUS_W = 2;

    // Input tdata layout, lowest bit first
    localparam int IN_OP_LSB  = 0;
    localparam int IN_VAL_LSB = IN_OP_LSB + OP_W;
    localparam int IN_OFF_LSB = IN_VAL_LSB + WORD_W;
    localparam int IN_BITS    = IN_OFF_LSB + OFF_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first (count sits above status)
    localparam int OUT_VAL_LSB = 0;
    localparam int OUT_ST_LSB  = OUT_VAL_LSB + WORD_W;
    localparam int OUT_CNT_LSB = OUT_ST_LSB + STATUS_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [OFF_W-1:0]  offset_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_DUP  = 3'd2,
        OP_SWAP = 3'd3,
        OP_ROT  = 3'd4,
        OP_PEEK = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Top three entries of the stack, held in flops
    typedef struct packed {
        word_t t0;   // entry count-1
        word_t t1;   // entry count-2
        word_t t2;   // entry count-3
    } top_regs_t;

    // Spill request from the op logic into the RAM
    typedef struct packed {
        logic  en;
        word_t data;
    } spill_t;

endpackage

### rtl/sdsr_ram.sv
// Generic simple RAM: one write port, two registered read ports.
module sdsr_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [W-1:0]             rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [W-1:0]             rdata_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/sdsr_alu.sv
// Single-pass stack operation logic on the cached top entries.
module sdsr_alu #(
    parameter int DEPTH = 64
) (
    input  sdsr_pkg::op_t                op,
    input  sdsr_pkg::word_t              push_value,
    input  sdsr_pkg::offset_t            peek_offset,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  sdsr_pkg::top_regs_t          tops,
    input  sdsr_pkg::word_t              refill,    // entry count-4
    input  sdsr_pkg::word_t              deep,      // entry count-1-offset
    output sdsr_pkg::top_regs_t          tops_next,
    output logic [$clog2(DEPTH+1)-1:0]   count_next,
    output sdsr_pkg::spill_t             spill,
    output logic [$clog2(DEPTH)-1:0]     spill_addr,
    output sdsr_pkg::word_t              rd_value,
    output sdsr_pkg::status_t            status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int DW = ((CW > sdsr_pkg::OFF_W) ? CW : sdsr_pkg::OFF_W) + 1;

    logic          full;
    logic          empty;
    logic          has3;
    logic [CW-1:0] cnt_m3;
    logic          off_bad;

    assign full    = (count >= CW'(DEPTH));
    assign empty   = (count == '0);
    assign has3    = (count >= CW'(3));
    assign cnt_m3  = count - CW'(3);
    assign off_bad = (DW'(peek_offset) >= DW'(count));
    assign spill_addr = cnt_m3[AW-1:0];

    always_comb begin
        tops_next  = tops;
        count_next = count;
        spill.en   = 1'b0;
        spill.data = tops.t2;
        rd_value   = '0;
        status     = sdsr_pkg::ST_OK;
        case (op)
            sdsr_pkg::OP_PUSH: begin
                if (full) begin
                    status = sdsr_pkg::ST_OVER;
                end else begin
                    tops_next.t0 = push_value;
                    tops_next.t1 = tops.t0;
                    tops_next.t2 = tops.t1;
                    count_next   = count + CW'(1);
                    spill.en     = has3;
                end
            end
            sdsr_pkg::OP_POP: begin
                if (empty) begin
                    status = sdsr_pkg::ST_UNDER;
                end else begin
                    rd_value     = tops.t0;
                    tops_next.t0 = tops.t1;
                    tops_next.t1 = tops.t2;
                    tops_next.t2 = refill;
                    count_next   = count - CW'(1);
                end
            end
            sdsr_pkg::OP_DUP: begin
                if (empty) begin
                    status = sdsr_pkg::ST_UNDER;
                end else if (full) begin
                    status = sdsr_pkg::ST_OVER;
                end else begin
                    tops_next.t1 = tops.t0;
                    tops_next.t2 = tops.t1;
                    count_next   = count + CW'(1);
                    spill.en     = has3;
                end
            end
            sdsr_pkg::OP_SWAP: begin
                if (count < CW'(2)) begin
                    status = sdsr_pkg::ST_UNDER;
                end else begin
                    tops_next.t0 = tops.t1;
                    tops_next.t1 = tops.t0;
                end
            end
            sdsr_pkg::OP_ROT: begin
                // ( a b c -- b c a ), a is the third entry
                if (!has3) begin
                    status = sdsr_pkg::ST_UNDER;
                end else begin
                    tops_next.t0 = tops.t2;
                    tops_next.t1 = tops.t0;
                    tops_next.t2 = tops.t1;
                end
            end
            sdsr_pkg::OP_PEEK: begin
                if (off_bad) begin
                    status = sdsr_pkg::ST_UNDER;
                end else begin
                    case (peek_offset)
                        sdsr_pkg::OFF_W'(0): rd_value = tops.t0;
                        sdsr_pkg::OFF_W'(1): rd_value = tops.t1;
                        sdsr_pkg::OFF_W'(2): rd_value = tops.t2;
                        default:             rd_value = deep;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/stack_with_dup_swap_rot.sv
// Top level of the bounded data stack with push, pop, dup, swap, rot and peek.
//
// Usage: one request on the s_ channel carries one operation; each request
// yields exactly one result on the m_ channel (read value, status, count).
// A failing operation leaves the stack unchanged and reports underflow or
// overflow in the status field.
// Requests pass through the input register and then the result register, which
// drives m_tvalid. Throughput: one request per cycle while m_tready is high.
// The top three entries live in flops; deeper entries live in a RAM with
// two registered read ports: one prefetches entry count-4 to refill the
// cache on pop, the other reads the peek target. Read addresses are
// computed from the count the next operation will see, so the data is
// ready when that operation executes; a same-cycle write is forwarded.
// Reset clears the count and both valid flags; the stack is empty and
// usable in the first cycle after reset. No RAM clearing pass.
// Stall: when m_tready is low with a result pending, the request in the
// input register waits and s_tready drops once that register is full; no
// request or result is lost or repeated.
module stack_with_dup_swap_rot #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: op[2:0], push_value[34:3], peek_offset[40:35], zero pad
    input  logic [sdsr_pkg::IN_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: read_value[31:0], status[33:32], count[..:34], zero pad
    output logic [((sdsr_pkg::OUT_CNT_LSB + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = ((CW > sdsr_pkg::OFF_W) ? CW : sdsr_pkg::OFF_W) + 1;
    localparam int OUT_W = ((sdsr_pkg::OUT_CNT_LSB + CW + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (sdsr_pkg::OUT_CNT_LSB + CW);

    // Input register
    logic                in_valid_reg;
    sdsr_pkg::op_t       in_op_reg;
    sdsr_pkg::word_t     in_val_reg;
    sdsr_pkg::offset_t   in_off_reg;

    // Stack state
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    sdsr_pkg::top_regs_t tops_reg;
    sdsr_pkg::top_regs_t tops_next;

    // Result register
    logic                out_valid_reg;
    sdsr_pkg::word_t     out_value_reg;
    sdsr_pkg::status_t   out_status_reg;
    logic [CW-1:0]       out_count_reg;

    // RAM side
    sdsr_pkg::spill_t    spill;
    logic [AW-1:0]       spill_addr;
    logic                ram_we;
    logic [AW-1:0]       rd_a_addr;
    logic [AW-1:0]       rd_b_addr;
    sdsr_pkg::word_t     ram_a_q;
    sdsr_pkg::word_t     ram_b_q;
    logic                hit_a_reg;
    logic                hit_b_reg;
    sdsr_pkg::word_t     fwd_data_reg;
    sdsr_pkg::word_t     refill;
    sdsr_pkg::word_t     deep;

    sdsr_pkg::word_t     rd_value;
    sdsr_pkg::status_t   status;

    logic                fire;
    logic                s_accept;
    logic [CW-1:0]       count_eff;
    sdsr_pkg::offset_t   off_eff;
    logic [CW:0]         refill_idx;
    logic [DW-1:0]       peek_idx;

    // Execute when a request waits and the result register can take it
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    sdsr_alu #(
        .DEPTH (DEPTH)
    ) u_alu (
        .op          (in_op_reg),
        .push_value  (in_val_reg),
        .peek_offset (in_off_reg),
        .count       (count_reg),
        .tops        (tops_reg),
        .refill      (refill),
        .deep        (deep),
        .tops_next   (tops_next),
        .count_next  (count_next),
        .spill       (spill),
        .spill_addr  (spill_addr),
        .rd_value    (rd_value),
        .status      (status)
    );

    // Count and offset seen by the request that executes next
    assign count_eff  = fire ? count_next : count_reg;
    assign off_eff    = s_accept ? s_tdata[sdsr_pkg::IN_OFF_LSB +: sdsr_pkg::OFF_W]
                                 : in_off_reg;
    assign refill_idx = {1'b0, count_eff} - (CW + 1)'(4);
    assign peek_idx   = DW'(count_eff) - DW'(1) - DW'(off_eff);
    assign rd_a_addr  = refill_idx[AW-1:0];
    assign rd_b_addr  = peek_idx[AW-1:0];
    assign ram_we     = fire && spill.en;

    sdsr_ram #(
        .W     (sdsr_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (spill_addr),
        .wdata   (spill.data),
        .raddr_a (rd_a_addr),
        .rdata_a (ram_a_q),
        .raddr_b (rd_b_addr),
        .rdata_b (ram_b_q)
    );

    // Forward a spill that lands on an address read in the same cycle
    always_ff @(posedge aclk) begin
        hit_a_reg    <= ram_we && (spill_addr == rd_a_addr);
        hit_b_reg    <= ram_we && (spill_addr == rd_b_addr);
        fwd_data_reg <= spill.data;
    end

    assign refill = hit_a_reg ? fwd_data_reg : ram_a_q;
    assign deep   = hit_b_reg ? fwd_data_reg : ram_b_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg  <= sdsr_pkg::op_t'(s_tdata[sdsr_pkg::IN_OP_LSB +: sdsr_pkg::OP_W]);
            in_val_reg <= s_tdata[sdsr_pkg::IN_VAL_LSB +: sdsr_pkg::WORD_W];
            in_off_reg <= s_tdata[sdsr_pkg::IN_OFF_LSB +: sdsr_pkg::OFF_W];
        end
        if (fire) begin
            tops_reg       <= tops_next;
            out_value_reg  <= rd_value;
            out_status_reg <= status;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_status_reg, out_value_reg};

endmodule

### rtl/sdsr_checker.sv
// Port-level checker for the data stack, bound to the top level.
module sdsr_checker #(
    parameter int DEPTH = 64
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [sdsr_pkg::IN_W-1:0]           s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((sdsr_pkg::OUT_CNT_LSB + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                   m_count;
    logic [sdsr_pkg::STATUS_W-1:0]   m_status;
    logic                            s_push;

    assign m_count  = m_tdata[sdsr_pkg::OUT_CNT_LSB +: CW];
    assign m_status = m_tdata[sdsr_pkg::OUT_ST_LSB +: sdsr_pkg::STATUS_W];
    assign s_push   = (s_tdata[sdsr_pkg::IN_OP_LSB +: sdsr_pkg::OP_W] == sdsr_pkg::OP_PUSH);

    // No result out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Count never exceeds the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_count <= CW'(DEPTH))
        else $error("count above depth");

    // Overflow is only reported on a full stack
    a_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == sdsr_pkg::ST_OVER) |-> m_count == CW'(DEPTH))
        else $error("overflow with free entries");

    // A push into an idle, empty stack shows count one once it has passed
    // through the input register and executed into the result register
    a_push_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_push && !m_tvalid && $past(!aresetn)
        |=> ##1 m_tvalid && (m_count == CW'(1)))
        else $error("first push after reset gave wrong count");

endmodule

bind stack_with_dup_swap_rot sdsr_checker #(
    .DEPTH (DEPTH)
) u_sdsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
